[hw/rtl/isocone_pkg.sv]
`default_nettype none

package isocone_pkg;

    // operation codes carried in tuser
    localparam logic OP_CANDIDATE = 1'b0;
    localparam logic OP_NEIGHBOR  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_CONE_RADIUS      = 2'd0;
    localparam logic [1:0] REG_PT_THRESHOLD     = 2'd1;
    localparam logic [1:0] REG_PT_FRACTION      = 2'd2;
    localparam logic [1:0] REG_ISOLATION_METHOD = 2'd3;

    // isolation methods
    localparam logic [1:0] METHOD_COUNT_THR = 2'd0;
    localparam logic [1:0] METHOD_SUM_THR   = 2'd1;
    localparam logic [1:0] METHOD_COUNT_FRC = 2'd2;
    localparam logic [1:0] METHOD_SUM_FRC   = 2'd3;

    localparam int MAX_LIST = 1024;

    // 2*pi in phi units of 1/512 rad
    localparam logic signed [13:0] TWO_PI_UNITS = 14'sd3217;
    localparam logic [11:0]        COUNT_MAX    = 12'd2048;
    localparam logic [26:0]        SUM_MAX      = 27'h7FF_FFFF;

    localparam logic [11:0] CONE_RADIUS_RST  = 12'd205;
    localparam logic [15:0] PT_THRESHOLD_RST = 16'd64;
    localparam logic [8:0]  PT_FRACTION_RST  = 9'd26;
    localparam logic [1:0]  METHOD_RST       = METHOD_COUNT_THR;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_DATA_W  = 16;

    typedef struct packed {
        logic        op;
        logic [15:0] pt;
        logic [12:0] eta;
        logic [12:0] phi;
        logic [9:0]  item_index;
        logic [10:0] skip_first;
        logic [10:0] skip_second;
        logic        track_matched;
        logic        last;
    } item_t;

endpackage

`default_nettype wire

[hw/rtl/isolation_cone_cut_top.sv]
// Cone isolation test over a stream of particles. A candidate beat (tuser = 0)
// loads the candidate pt, eta, phi and two list indexes to skip, latches
// pt_fraction * pt and clears the pt sum and both counters. Each following
// neighbor beat (tuser = 1) that is neither skipped nor track-matched is tested
// against the cone (deta^2 + dphi^2 < cone_radius^2, negative neighbor phi
// shifted by 2*pi) and, inside the cone, adds to the saturating pt sum, the
// count over pt_threshold and the count over the candidate fraction. A beat
// with tlast reports both counts, the sum and the isolated flag for the chosen
// method. One beat is taken every clock cycle while no tlast beat waits for the
// master side; the beat lands in the input register on the accepting edge, and
// the combinational cone test and accumulator update then load the result
// register that drives the master side. A tlast beat waits in the input
// register only while an earlier result is still held on the master side. The
// accumulators are updated once per cycle, which is what sets the rate. The
// configuration port is always ready; registers are to be written only while
// no beat is in flight.
`default_nettype none

module isolation_cone_cut_top
    import isocone_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration write channel
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // pt[15:0], eta[28:16], phi[41:29], item_index[51:42], skip_first[62:52],
    // skip_second[73:63], track_matched[74], zero[79:75]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   s_tuser,   // operation
    input  wire logic                   s_tlast,   // last
    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // isolated[0], count_over_threshold[12:1], count_over_fraction[24:13],
    // cone_pt_sum[51:25], zero[55:52]
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    // configuration
    logic [11:0] cone_radius_reg;
    logic [15:0] pt_threshold_reg;
    logic [8:0]  pt_fraction_reg;
    logic [1:0]  method_reg;

    // input stage
    item_t s1_reg;
    logic  s1_valid_reg;

    // candidate and accumulator state
    logic [15:0] cand_pt_reg,        cand_pt_next;
    logic [12:0] cand_eta_reg,       cand_eta_next;
    logic [12:0] cand_phi_reg,       cand_phi_next;
    logic [10:0] skip_a_reg,         skip_a_next;
    logic [10:0] skip_b_reg,         skip_b_next;
    logic [24:0] fraction_limit_reg, fraction_limit_next;
    logic [26:0] pt_sum_reg,         pt_sum_next;
    logic [11:0] thr_count_reg,      thr_count_next;
    logic [11:0] frac_count_reg,     frac_count_next;

    // result stage
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic out_free;
    logic fire;
    logic in_accept;

    logic signed [12:0] nb_eta;
    logic signed [12:0] nb_phi;
    logic signed [13:0] nb_phi_wrapped;
    logic signed [14:0] deta;
    logic signed [14:0] dphi;
    logic [29:0]        deta_sq;
    logic [29:0]        dphi_sq;
    logic [30:0]        dist_sq;
    logic [23:0]        radius_sq;
    logic               in_cone;
    logic               hit_a;
    logic               hit_b;
    logic               counted;
    logic [27:0]        sum_wide;
    logic               isolated;

    function automatic logic skip_hit(input logic [10:0] s, input logic [9:0] idx);
        return !s[10] && (32'(s) < MAX_LIST) && (s[9:0] == idx);
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cone_radius_reg  <= CONE_RADIUS_RST;
            pt_threshold_reg <= PT_THRESHOLD_RST;
            pt_fraction_reg  <= PT_FRACTION_RST;
            method_reg       <= METHOD_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_CONE_RADIUS:      cone_radius_reg  <= cfg_data[11:0];
                REG_PT_THRESHOLD:     pt_threshold_reg <= cfg_data[15:0];
                REG_PT_FRACTION:      pt_fraction_reg  <= cfg_data[8:0];
                REG_ISOLATION_METHOD: method_reg       <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // a beat without tlast never needs the result slot
    assign out_free  = !m_tvalid_reg || m_tready;
    assign fire      = s1_valid_reg && (!s1_reg.last || out_free);
    assign s_tready  = !s1_valid_reg || fire;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_reg.op            <= s_tuser;
            s1_reg.pt            <= s_tdata[15:0];
            s1_reg.eta           <= s_tdata[28:16];
            s1_reg.phi           <= s_tdata[41:29];
            s1_reg.item_index    <= s_tdata[51:42];
            s1_reg.skip_first    <= s_tdata[62:52];
            s1_reg.skip_second   <= s_tdata[73:63];
            s1_reg.track_matched <= s_tdata[74];
            s1_reg.last          <= s_tlast;
        end
    end

    // cone test
    assign nb_eta         = $signed(s1_reg.eta);
    assign nb_phi         = $signed(s1_reg.phi);
    assign nb_phi_wrapped = nb_phi[12] ? (14'(nb_phi) + TWO_PI_UNITS) : 14'(nb_phi);
    assign deta           = 15'(nb_eta) - 15'($signed(cand_eta_reg));
    assign dphi           = 15'(nb_phi_wrapped) - 15'($signed(cand_phi_reg));
    assign deta_sq        = 30'(deta * deta);
    assign dphi_sq        = 30'(dphi * dphi);
    assign dist_sq        = {1'b0, deta_sq} + {1'b0, dphi_sq};
    assign radius_sq      = cone_radius_reg * cone_radius_reg;
    assign in_cone        = dist_sq < {7'b0, radius_sq};

    assign hit_a   = skip_hit(skip_a_reg, s1_reg.item_index);
    assign hit_b   = skip_hit(skip_b_reg, s1_reg.item_index);
    assign counted = (s1_reg.op == OP_NEIGHBOR) && !hit_a && !hit_b
                     && !s1_reg.track_matched && in_cone;
    assign sum_wide = {1'b0, pt_sum_reg} + {12'b0, s1_reg.pt};

    always_comb begin
        cand_pt_next        = cand_pt_reg;
        cand_eta_next       = cand_eta_reg;
        cand_phi_next       = cand_phi_reg;
        skip_a_next         = skip_a_reg;
        skip_b_next         = skip_b_reg;
        fraction_limit_next = fraction_limit_reg;
        pt_sum_next         = pt_sum_reg;
        thr_count_next      = thr_count_reg;
        frac_count_next     = frac_count_reg;
        if (s1_reg.op == OP_CANDIDATE) begin
            cand_pt_next        = s1_reg.pt;
            cand_eta_next       = s1_reg.eta;
            cand_phi_next       = s1_reg.phi;
            skip_a_next         = s1_reg.skip_first;
            skip_b_next         = s1_reg.skip_second;
            fraction_limit_next = pt_fraction_reg * s1_reg.pt;
            pt_sum_next         = '0;
            thr_count_next      = '0;
            frac_count_next     = '0;
        end else if (counted) begin
            pt_sum_next = sum_wide[27] ? SUM_MAX : sum_wide[26:0];
            if (s1_reg.pt > pt_threshold_reg && thr_count_reg < COUNT_MAX) begin
                thr_count_next = thr_count_reg + 12'd1;
            end
            if ({1'b0, s1_reg.pt, 8'b0} > fraction_limit_reg
                && frac_count_reg < COUNT_MAX) begin
                frac_count_next = frac_count_reg + 12'd1;
            end
        end
    end

    always_comb begin
        case (method_reg)
            METHOD_COUNT_THR: isolated = thr_count_next == '0;
            METHOD_SUM_THR:   isolated = pt_sum_next < {11'b0, pt_threshold_reg};
            METHOD_COUNT_FRC: isolated = frac_count_next == '0;
            METHOD_SUM_FRC:   isolated = {pt_sum_next, 8'b0} < {10'b0, fraction_limit_next};
            default:          isolated = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_pt_reg        <= '0;
            cand_eta_reg       <= '0;
            cand_phi_reg       <= '0;
            skip_a_reg         <= '1;
            skip_b_reg         <= '1;
            fraction_limit_reg <= '0;
            pt_sum_reg         <= '0;
            thr_count_reg      <= '0;
            frac_count_reg     <= '0;
        end else if (fire) begin
            cand_pt_reg        <= cand_pt_next;
            cand_eta_reg       <= cand_eta_next;
            cand_phi_reg       <= cand_phi_next;
            skip_a_reg         <= skip_a_next;
            skip_b_reg         <= skip_b_next;
            fraction_limit_reg <= fraction_limit_next;
            pt_sum_reg         <= pt_sum_next;
            thr_count_reg      <= thr_count_next;
            frac_count_reg     <= frac_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fire && s1_reg.last) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && s1_reg.last) begin
            m_tdata_reg <= {4'b0, pt_sum_next, frac_count_next, thr_count_next, isolated};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a result only shows up after a tlast beat is processed
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(fire && s1_reg.last))
        else $error("result raised without a processed tlast beat");

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && s1_reg.last) |=> m_tvalid_reg)
        else $error("tlast beat processed but no result held");

    a_counts_saturate: assert property (@(posedge aclk) disable iff (!aresetn)
        (thr_count_reg <= COUNT_MAX) && (frac_count_reg <= COUNT_MAX))
        else $error("counter went past its saturation value");

    a_candidate_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && s1_reg.op == OP_CANDIDATE) |=>
            (pt_sum_reg == '0) && (thr_count_reg == '0) && (frac_count_reg == '0))
        else $error("accumulators not cleared by candidate beat");

    a_stall_holds_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !fire) |=> s1_valid_reg && $stable(s1_reg))
        else $error("stalled item lost from input stage");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
module tb
    import isocone_pkg::*;
();

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 5;
    localparam int RANDOM_BEATS = 580;
    localparam int PILE_BEATS   = 60;

    // lowest bit first: isolated, thr count, frac count, pt sum
    typedef struct packed {
        logic [26:0] pt_sum;
        logic [11:0] frc_count;
        logic [11:0] thr_count;
        logic        isolated;
    } report_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [1:0]             cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // pt, eta, phi, item_index, skip_first, skip_second, track_matched, zero fill
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;   // operation
    logic                   s_tlast   = 1'b0;   // last
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // isolated, count_over_threshold, count_over_fraction, cone_pt_sum, zero fill
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic quiet    = 1'b0;
    logic hold_req = 1'b0;

    // predictor copy of the registers
    logic [11:0] radius;
    logic [15:0] thr_level;
    logic [8:0]  frac_q8;
    logic [1:0]  method_sel;

    // predictor copy of the candidate and the accumulators
    logic        [15:0] c_pt;
    logic signed [12:0] c_eta, c_phi;
    logic signed [10:0] veto_a, veto_b;
    logic        [24:0] frac_bound;
    logic        [26:0] cone_sum;
    logic        [11:0] n_over_thr, n_over_frc;

    report_t iso_reports[$];

    int errors     = 0;
    int n_items    = 0;
    int n_reports  = 0;
    int n_settings = 1;
    int rx_stall   = 0;
    int idle_run   = 0;

    isolation_cone_cut_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = int'($urandom_range(0, 99));
        if (r < 60)
            return 0;
        if (r < 88)
            return int'($urandom_range(1, 3));
        if (r < 97)
            return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic item_t mk(logic op, int pt, int eta, int phi, int idx, int s1, int s2,
                                 logic matched, logic last);
        item_t it;
        it.op            = op;
        it.pt            = 16'(pt);
        it.eta           = 13'(eta);
        it.phi           = 13'(phi);
        it.item_index    = 10'(idx);
        it.skip_first    = 11'(s1);
        it.skip_second   = 11'(s2);
        it.track_matched = matched;
        it.last          = last;
        return it;
    endfunction

    function automatic bit vetoed(logic signed [10:0] s, logic [9:0] idx);
        return s >= 0 && int'(s) < MAX_LIST && s[9:0] == idx;
    endfunction

    function automatic void reset_isolation_state();
        radius     = CONE_RADIUS_RST;
        thr_level  = PT_THRESHOLD_RST;
        frac_q8    = PT_FRACTION_RST;
        method_sel = METHOD_RST;
        c_pt       = '0;
        c_eta      = '0;
        c_phi      = '0;
        veto_a     = '1;
        veto_b     = '1;
        frac_bound = '0;
        cone_sum   = '0;
        n_over_thr = '0;
        n_over_frc = '0;
    endfunction

    task automatic predict_isolation(input item_t it);
        int      eta_n, phi_n;
        longint  de, dp, rr, sum_next;
        report_t rep;
        if (it.op == OP_CANDIDATE) begin
            c_pt       = it.pt;
            c_eta      = it.eta;
            c_phi      = it.phi;
            veto_a     = it.skip_first;
            veto_b     = it.skip_second;
            frac_bound = 25'(int'(frac_q8) * int'(c_pt));
            cone_sum   = '0;
            n_over_thr = '0;
            n_over_frc = '0;
        end else if (!vetoed(veto_a, it.item_index) && !vetoed(veto_b, it.item_index) &&
                     !it.track_matched) begin
            eta_n = int'($signed(it.eta));
            phi_n = int'($signed(it.phi));
            if (phi_n < 0)
                phi_n += int'(TWO_PI_UNITS);
            de = longint'(eta_n - int'(c_eta));
            dp = longint'(phi_n - int'(c_phi));
            rr = longint'(radius);
            if (de * de + dp * dp < rr * rr) begin
                sum_next = longint'(cone_sum) + longint'(it.pt);
                cone_sum = (sum_next > longint'(SUM_MAX)) ? SUM_MAX : 27'(sum_next);
                if (it.pt > thr_level && n_over_thr < COUNT_MAX)
                    n_over_thr++;
                if ({it.pt, 8'd0} > frac_bound && n_over_frc < COUNT_MAX)
                    n_over_frc++;
            end
        end
        if (it.last) begin
            case (method_sel)
                METHOD_COUNT_THR: rep.isolated = (n_over_thr == 0);
                METHOD_SUM_THR:   rep.isolated = (cone_sum < thr_level);
                METHOD_COUNT_FRC: rep.isolated = (n_over_frc == 0);
                default:          rep.isolated = ({cone_sum, 8'd0} < frac_bound);
            endcase
            rep.thr_count = n_over_thr;
            rep.frc_count = n_over_frc;
            rep.pt_sum    = cone_sum;
            iso_reports.push_back(rep);
        end
    endtask

    task automatic send_item(input item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, it.track_matched, it.skip_second, it.skip_first, it.item_index,
                     it.phi, it.eta, it.pt};
        s_tuser  <= it.op;
        s_tlast  <= it.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_isolation(it);
        n_items++;
    endtask

    // stop offering, wait for every report and let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (iso_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_CONE_RADIUS:  radius     = 12'(val);
            REG_PT_THRESHOLD: thr_level  = 16'(val);
            REG_PT_FRACTION:  frac_q8    = 9'(val);
            default:          method_sel = 2'(val);
        endcase
    endtask

    task automatic load_regs(input int r, input int t, input int f, input logic [1:0] m);
        write_reg(REG_CONE_RADIUS, r);
        write_reg(REG_PT_THRESHOLD, t);
        write_reg(REG_PT_FRACTION, f);
        write_reg(REG_ISOLATION_METHOD, int'(m));
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    function automatic int rnd_pt();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 65535;
            2, 3, 4: return int'($urandom_range(0, 255));
            5, 6:    return clamp(int'(thr_level) + int'($urandom_range(0, 8)) - 4, 0, 65535);
            default: return int'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic int rnd_phi();
        return int'($urandom_range(0, 4825)) - 1609;
    endfunction

    function automatic int rnd_skip();
        int r;
        r = int'($urandom_range(0, 9));
        if (r < 3)
            return -1;
        if (r < 8)
            return int'($urandom_range(0, 12));
        return int'($urandom_range(0, 1023));
    endfunction

    // one candidate and its neighbors scattered around the cone edge
    task automatic send_group();
        int n, ce, cp, e, p, span, idx;
        n    = int'($urandom_range(0, 10));
        ce   = int'($urandom_range(0, 8191)) - 4096;
        cp   = ($urandom_range(0, 4) == 0) ? rnd_phi() : int'($urandom_range(0, 3216));
        span = int'(radius) + int'(radius) / 4 + 8;
        send_item(mk(OP_CANDIDATE, rnd_pt(), ce, cp, int'($urandom_range(0, 1023)),
                     rnd_skip(), rnd_skip(), 1'($urandom_range(0, 1)),
                     n == 0 || $urandom_range(0, 19) == 0));
        for (int i = 0; i < n; i++) begin
            e = clamp(ce + int'($urandom_range(0, 2 * span)) - span, -4096, 4095);
            p = clamp(cp + int'($urandom_range(0, 2 * span)) - span, -1609, 3216);
            // same spot seen from below zero
            if (p >= 1608 && $urandom_range(0, 3) == 0)
                p -= int'(TWO_PI_UNITS);
            idx = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 1023)) : i;
            send_item(mk(OP_NEIGHBOR, rnd_pt(), e, p, idx, rnd_skip(), rnd_skip(),
                         $urandom_range(0, 9) == 0,
                         (i == n - 1) && $urandom_range(0, 9) != 0));
        end
    endtask

    task automatic send_noise();
        send_item(mk(1'($urandom_range(0, 1)), int'($urandom_range(0, 65535)),
                     int'($urandom_range(0, 8191)) - 4096, rnd_phi(),
                     int'($urandom_range(0, 1023)), int'($urandom_range(0, 1024)) - 1,
                     int'($urandom_range(0, 1024)) - 1, 1'($urandom_range(0, 1)),
                     $urandom_range(0, 2) == 0));
    endtask

    task automatic test_directed_corners();
        // neighbor ahead of any candidate uses the cleared candidate
        send_item(mk(OP_NEIGHBOR, 100, 10, 10, 7, 0, 0, 1'b0, 1'b1));
        send_item(mk(OP_CANDIDATE, 65535, 4095, 3216, 0, -1, 1023, 1'b1, 1'b1));
        send_item(mk(OP_NEIGHBOR, 65535, 4095, 3216, 1023, 0, 0, 1'b0, 1'b0));
        // track-matched neighbor still closes the candidate
        send_item(mk(OP_NEIGHBOR, 65535, 4000, 3100, 0, 0, 0, 1'b1, 1'b1));
        send_item(mk(OP_NEIGHBOR, 0, 4095, 3216, 0, 0, 0, 1'b0, 1'b0));
        send_item(mk(OP_NEIGHBOR, 65535, 4095, -1, 1, 0, 0, 1'b0, 1'b1));
        // no new candidate, keeps piling onto the old sums
        send_item(mk(OP_NEIGHBOR, 1000, 4050, 3200, 2, 0, 0, 1'b0, 1'b1));
        send_item(mk(OP_NEIGHBOR, 500, 4095, 3216, 1023, 0, 0, 1'b0, 1'b1));
        // negative candidate phi is not wrapped
        send_item(mk(OP_CANDIDATE, 0, -4096, -1609, 3, -1, 0, 1'b0, 1'b0));
        send_item(mk(OP_NEIGHBOR, 500, -4096, -1609, 4, 0, 0, 1'b0, 1'b0));
        send_item(mk(OP_NEIGHBOR, 65535, -4000, 0, 3, 0, 0, 1'b0, 1'b0));
        send_item(mk(OP_NEIGHBOR, 1, -4096, 0, 5, 0, 0, 1'b0, 1'b1));
        send_item(mk(OP_CANDIDATE, 1000, 0, 0, 0, -1, -1, 1'b0, 1'b0));
        // exactly on the cone edge is outside
        send_item(mk(OP_NEIGHBOR, 65535, 205, 0, 0, 0, 0, 1'b0, 1'b0));
        send_item(mk(OP_NEIGHBOR, 64, 204, 0, 1, 0, 0, 1'b0, 1'b0));
        send_item(mk(OP_NEIGHBOR, 65, 0, 204, 2, 0, 0, 1'b0, 1'b0));
        // fraction compare just above and just below
        send_item(mk(OP_NEIGHBOR, 102, -100, 100, 3, 0, 0, 1'b0, 1'b0));
        send_item(mk(OP_NEIGHBOR, 101, -100, 150, 1023, 0, 0, 1'b0, 1'b1));
        settle();
    endtask

    task automatic test_register_extremes();
        load_regs(0, 0, 0, METHOD_COUNT_THR);
        repeat (3) send_group();
        settle();
        load_regs(4095, 65535, 256, METHOD_SUM_THR);
        repeat (3) send_group();
        settle();
        load_regs(4095, 0, 256, METHOD_COUNT_FRC);
        repeat (3) send_group();
        settle();
        load_regs(1, 65535, 0, METHOD_SUM_FRC);
        repeat (3) send_group();
        settle();
        load_regs(4095, 65535, 256, METHOD_SUM_FRC);
        repeat (3) send_group();
        settle();
    endtask

    // fraction limit stays latched, the rest takes effect at once
    task automatic test_register_change_mid_candidate();
        load_regs(300, 100, 128, METHOD_SUM_FRC);
        send_item(mk(OP_CANDIDATE, 2000, 100, 1000, 0, 1, 2, 1'b0, 1'b0));
        send_item(mk(OP_NEIGHBOR, 900, 150, 1050, 3, 0, 0, 1'b0, 1'b0));
        send_item(mk(OP_NEIGHBOR, 1200, 50, 950, 4, 0, 0, 1'b0, 1'b0));
        send_item(mk(OP_NEIGHBOR, 30, 100, 1000, 5, 0, 0, 1'b0, 1'b1));
        settle();
        load_regs(600, 0, 256, METHOD_COUNT_FRC);
        send_item(mk(OP_NEIGHBOR, 1001, 400, 1200, 6, 0, 0, 1'b0, 1'b0));
        send_item(mk(OP_NEIGHBOR, 999, 100, 1000, 1, 0, 0, 1'b0, 1'b1));
        settle();
        load_regs(0, 65535, 0, METHOD_SUM_THR);
        send_item(mk(OP_NEIGHBOR, 4000, 100, 1000, 7, 0, 0, 1'b0, 1'b1));
        settle();
    endtask

    // a long run of full-scale pt into one cone, reported along the way
    task automatic test_large_sums();
        load_regs(4095, 0, 0, METHOD_SUM_FRC);
        send_item(mk(OP_CANDIDATE, 0, 0, 0, 0, -1, -1, 1'b0, 1'b0));
        for (int i = 0; i < PILE_BEATS; i++)
            send_item(mk(OP_NEIGHBOR, 65535, 0, 0, i % MAX_LIST, 0, 0, 1'b0,
                         (i % 16 == 15) || i == PILE_BEATS - 1));
        settle();
    endtask

    task automatic test_backpressure();
        load_regs(int'(CONE_RADIUS_RST), int'(PT_THRESHOLD_RST), int'(PT_FRACTION_RST),
                  METHOD_COUNT_FRC);
        quiet    <= 1'b1;
        hold_req <= 1'b1;
        for (int i = 0; i < 40; i++) begin
            if (i % 2 == 0)
                send_item(mk(OP_CANDIDATE, rnd_pt(), i, 500, 0, -1, -1, 1'b0, 1'b1));
            else
                send_item(mk(OP_NEIGHBOR, rnd_pt(), i + 30, 520, i, 0, 0, 1'b0, 1'b1));
        end
        settle();
        quiet <= 1'b0;
    endtask

    task automatic test_random_streams();
        int start, goal, phase;
        int r, t, f;
        start = n_items;
        phase = 0;
        while (n_items - start < RANDOM_BEATS) begin
            case ($urandom_range(0, 3))
                0:       r = ($urandom_range(0, 1) == 0) ? 0 : 4095;
                default: r = int'($urandom_range(1, 600));
            endcase
            case ($urandom_range(0, 3))
                0:       t = ($urandom_range(0, 1) == 0) ? 0 : 65535;
                default: t = int'($urandom_range(0, 2000));
            endcase
            case ($urandom_range(0, 3))
                0:       f = ($urandom_range(0, 1) == 0) ? 0 : 256;
                default: f = int'($urandom_range(0, 256));
            endcase
            load_regs(r, t, f, 2'($urandom_range(0, 3)));
            quiet <= (phase % 4 == 3);
            goal = n_items + int'($urandom_range(60, 140));
            while (n_items < goal) begin
                if ($urandom_range(0, 6) == 0)
                    send_noise();
                else
                    send_group();
            end
            settle();
            phase++;
        end
        quiet <= 1'b0;
    endtask

    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : report_check
        report_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[51:0];
            if (iso_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none, got %h", $time, m_tdata);
                errors++;
            end else begin
                want = iso_reports.pop_front();
                check_field("isolated", want.isolated, got.isolated);
                check_field("count_over_threshold", want.thr_count, got.thr_count);
                check_field("count_over_fraction", want.frc_count, got.frc_count);
                check_field("cone_pt_sum", want.pt_sum, got.pt_sum);
                n_reports++;
            end
        end
    end

    // result side: random stalls, plus one long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else if (hold_req) begin
            rx_stall = HOLD_CYCLES;
            hold_req <= 1'b0;
            m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall = rx_stall - 1;
            m_tready <= 1'b0;
        end else begin
            rx_stall = pick_gap();
            m_tready <= (rx_stall == 0);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_run = 0;
        else
            idle_run++;
        if (idle_run >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        reset_isolation_state();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_corners();
        test_register_extremes();
        test_register_change_mid_candidate();
        test_large_sums();
        test_backpressure();
        test_random_streams();
        $display("%0d input beats sent, %0d reports checked, %0d register settings used",
                 n_items, n_reports, n_settings);
        $display("covered cone edges, skips, phi wrap, large pt sums, a %0d-cycle output hold",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/isocone_pkg.sv
hw/rtl/isolation_cone_cut_top.sv
tb/sv/tb.sv
